/* hw/rtl/rwlt_pkg.sv */
// Package for the reader-writer lock table: sizes, operation codes, lock word type
// and small helpers. Used by every file of the block; depends on nothing.

package rwlt_pkg;

    localparam int NUM_LOCKS  = 64;
    localparam int COUNT_BITS = 16;

    localparam int KIND_W  = 3;
    localparam int ID_W    = 6;
    localparam int OCNT_W  = 16;
    localparam int CNT_W   = COUNT_BITS;
    localparam int ADDR_W  = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam int WIDE_W  = 64;

    typedef enum logic [KIND_W-1:0] {
        K_CLEAR   = 3'd0,
        K_RD_TRY  = 3'd1,
        K_RD_REL  = 3'd2,
        K_WR_TRY  = 3'd3,
        K_WR_LOCK = 3'd4,
        K_DOWNGR  = 3'd5,
        K_WR_REL  = 3'd6
    } t_kind;

    typedef struct packed {
        logic             writer;
        logic             waiting;
        logic [CNT_W-1:0] count;
    } t_word;

    typedef struct packed {
        logic  granted;
        t_word word;
    } t_upd;

    // Lock index into memory address; the table holds at most 4096 words.
    function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_W-1:0] id);
        logic [11:0] wide;
        wide = 12'(id);
        return wide[ADDR_W-1:0];
    endfunction

    function automatic logic out_of_range(input logic [ID_W-1:0] id);
        return 13'(id) >= 13'(NUM_LOCKS);
    endfunction

    function automatic logic [OCNT_W-1:0] count_out(input logic [CNT_W-1:0] cnt);
        logic [WIDE_W-1:0] wide;
        wide = WIDE_W'(cnt);
        return wide[OCNT_W-1:0];
    endfunction

endpackage

/* hw/rtl/rwlt_if.sv */
// Valid/ready channels of the reader-writer lock table: request and response.
// Depends on rwlt_pkg for field widths.

interface rwlt_req_if;
    logic                          valid;
    logic                          ready;
    logic [rwlt_pkg::KIND_W-1:0]   kind;
    logic [rwlt_pkg::ID_W-1:0]     lock_id;

    modport source (output valid, output kind, output lock_id, input ready);
    modport sink   (input valid, input kind, input lock_id, output ready);
endinterface

interface rwlt_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [rwlt_pkg::OCNT_W-1:0]   reader_count;
    logic                          writer_held;
    logic                          writer_waiting;

    modport source (output valid, output granted, output reader_count,
                    output writer_held, output writer_waiting, input ready);
    modport sink   (input valid, input granted, input reader_count,
                    input writer_held, input writer_waiting, output ready);
endinterface

/* hw/rtl/reader_writer_lock_table.sv */
// Top level of the reader-writer lock table: lock word memory, read-modify-write
// pipeline and response register. Depends on rwlt_pkg, rwlt_if.sv and rwlt_update.
//
// Usage:
//   i_req carries one request item (kind, lock_id); o_rsp returns exactly one
//   response item (granted, reader_count, writer_held, writer_waiting) per
//   request, in request order. Both are valid/ready channels.
//   A request accepted passes the update stage and then the response register
//   before it appears on o_rsp.
//   Throughput: one item per cycle while o_rsp is not stalled. Lock words are
//   read on acceptance and written as the item leaves the update stage; the
//   previous item's write is forwarded to the next one on the same lock.
//   Reset (i_rst_n low, synchronous) empties the pipeline and marks every lock
//   word as unlocked through a valid bit per word; no clearing pass is needed
//   and requests are taken in the first cycle after reset.
//   When o_rsp is stalled the response register holds, the item in the update
//   stage waits behind it, and i_req.ready drops once both are full.
//   A lock_id beyond the table gives an all-zero response and changes nothing;
//   kind 7 changes nothing and reports the named word with granted low.

module reader_writer_lock_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    rwlt_req_if.sink           i_req,
    rwlt_rsp_if.source         o_rsp
);

    localparam int AW = rwlt_pkg::ADDR_W;

    // lock word memory with a valid bit per word
    rwlt_pkg::t_word                 mem [rwlt_pkg::NUM_LOCKS];
    logic [rwlt_pkg::NUM_LOCKS-1:0]  r_valid;

    // update stage
    logic                            r_s1_vld;
    logic [rwlt_pkg::KIND_W-1:0]     r_s1_kind;
    logic [AW-1:0]                   r_s1_addr;
    logic                            r_s1_oob;
    rwlt_pkg::t_word                 r_rd_word;
    logic                            r_rd_vld;

    // last write, for forwarding
    logic                            r_wb_vld;
    logic [AW-1:0]                   r_wb_addr;
    rwlt_pkg::t_word                 r_wb_word;

    // response register
    logic                            r_out_vld;
    logic                            r_out_granted;
    rwlt_pkg::t_word                 r_out_word;

    logic                            out_free;
    logic                            s1_adv;
    logic                            in_acc;
    logic                            fwd;
    logic                            we;
    logic [AW-1:0]                   in_addr;
    rwlt_pkg::t_word                 cur_word;
    rwlt_pkg::t_upd                  upd;
    logic                            n_out_granted;
    rwlt_pkg::t_word                 n_out_word;

    rwlt_update u_update (
        .i_kind (r_s1_kind),
        .i_word (cur_word),
        .o_upd  (upd)
    );

    always_comb begin
        out_free    = !r_out_vld || o_rsp.ready;
        s1_adv      = r_s1_vld && out_free;
        i_req.ready = !r_s1_vld || out_free;
        in_acc      = i_req.valid && i_req.ready;
        in_addr     = rwlt_pkg::to_addr(i_req.lock_id);
        fwd         = r_wb_vld && (r_wb_addr == r_s1_addr);
        if (fwd) begin
            cur_word = r_wb_word;
        end else if (r_rd_vld) begin
            cur_word = r_rd_word;
        end else begin
            cur_word = '0;
        end
        we = s1_adv && !r_s1_oob;
        if (r_s1_oob) begin
            n_out_granted = 1'b0;
            n_out_word    = '0;
        end else begin
            n_out_granted = upd.granted;
            n_out_word    = upd.word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_wb_vld  <= 1'b0;
            r_valid   <= '0;
        end else begin
            if (i_req.ready) begin
                r_s1_vld <= in_acc;
            end
            if (out_free) begin
                r_out_vld <= r_s1_vld;
            end
            if (we) begin
                r_wb_vld           <= 1'b1;
                r_valid[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[r_s1_addr] <= upd.word;
            r_wb_addr      <= r_s1_addr;
            r_wb_word      <= upd.word;
        end
        if (in_acc) begin
            r_rd_word <= mem[in_addr];
            r_rd_vld  <= r_valid[in_addr];
            r_s1_kind <= i_req.kind;
            r_s1_addr <= in_addr;
            r_s1_oob  <= rwlt_pkg::out_of_range(i_req.lock_id);
        end
        if (s1_adv) begin
            r_out_granted <= n_out_granted;
            r_out_word    <= n_out_word;
        end
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.granted        = r_out_granted;
    assign o_rsp.reader_count   = rwlt_pkg::count_out(r_out_word.count);
    assign o_rsp.writer_held    = r_out_word.writer;
    assign o_rsp.writer_waiting = r_out_word.waiting;

    // a lock word never has a writer and readers at once
    a_no_mixed_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> !(upd.word.writer && (upd.word.count != '0)))
        else $error("lock word written with writer and readers");

    // memory written only by an item leaving the update stage
    a_write_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (r_s1_vld && out_free))
        else $error("lock word written without an advancing item");

    // request side only blocks while the update stage and the response register are both occupied
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_s1_vld && r_out_vld))
        else $error("request refused with room in the pipeline");

    // a write leaves the forwarding register pointing at the word written
    a_fwd_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> (r_wb_vld && r_valid[r_wb_addr]))
        else $error("forwarding register out of step with memory");

endmodule

/* hw/rtl/rwlt_update.sv */
// Lock word update: applies one operation to the current word.
// Depends on rwlt_pkg.

module rwlt_update (
    input  logic [rwlt_pkg::KIND_W-1:0] i_kind,
    input  rwlt_pkg::t_word             i_word,
    output rwlt_pkg::t_upd              o_upd
);

    logic cnt_zero;
    logic cnt_full;

    always_comb begin
        cnt_zero      = (i_word.count == '0);
        cnt_full      = &i_word.count;
        o_upd.granted = 1'b0;
        o_upd.word    = i_word;
        case (rwlt_pkg::t_kind'(i_kind))
            rwlt_pkg::K_CLEAR: begin
                o_upd.word    = '0;
                o_upd.granted = 1'b1;
            end
            rwlt_pkg::K_RD_TRY: begin
                // saturates: a full count refuses rather than wrap
                if (!i_word.writer && !i_word.waiting && !cnt_full) begin
                    o_upd.word.count = i_word.count + rwlt_pkg::CNT_W'(1);
                    o_upd.granted    = 1'b1;
                end
            end
            rwlt_pkg::K_RD_REL: begin
                if (!cnt_zero) begin
                    o_upd.word.count = i_word.count - rwlt_pkg::CNT_W'(1);
                    o_upd.granted    = 1'b1;
                end
            end
            rwlt_pkg::K_WR_TRY: begin
                if (!i_word.writer && cnt_zero) begin
                    o_upd.word.writer  = 1'b1;
                    o_upd.word.waiting = 1'b0;
                    o_upd.granted      = 1'b1;
                end else begin
                    o_upd.word.waiting = 1'b1;
                end
            end
            rwlt_pkg::K_WR_LOCK: begin
                if (!i_word.writer && !i_word.waiting && cnt_zero) begin
                    o_upd.word.writer = 1'b1;
                    o_upd.granted     = 1'b1;
                end
            end
            rwlt_pkg::K_DOWNGR: begin
                if (i_word.writer) begin
                    o_upd.word.writer = 1'b0;
                    o_upd.word.count  = rwlt_pkg::CNT_W'(1);
                    o_upd.granted     = 1'b1;
                end
            end
            rwlt_pkg::K_WR_REL: begin
                if (i_word.writer) begin
                    o_upd.word.writer = 1'b0;
                    o_upd.granted     = 1'b1;
                end
            end
            default: begin
                o_upd.granted = 1'b0;
            end
        endcase
    end

endmodule
